// File: src/legged_motion_command_arbiter_assert.svh
// Assertion macros for the legged motion command arbiter.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef LEGGED_MOTION_COMMAND_ARBITER_ASSERT_SVH
`define LEGGED_MOTION_COMMAND_ARBITER_ASSERT_SVH
// hold a property at every clock edge out of reset
`define LMCA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lmca assertion failed");
// require a consequence in the cycle after a condition
`define LMCA_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("lmca assertion failed");
`endif

// File: src/lmca_pkg.sv
// Shared constants for the legged motion command arbiter.
// No dependencies; used by the top level and the serial arithmetic units.
`timescale 1ns / 1ps
package lmca_pkg;
  localparam int QW = 15;
  localparam int MAGW = 11;
  localparam int SCW = 10;
  localparam int CW = 16;

  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_GET_UP   = 3'd1;
  localparam logic [2:0] MODE_STAND    = 3'd2;
  localparam logic [2:0] MODE_WALK     = 3'd3;
  localparam logic [2:0] MODE_TURN     = 3'd4;
  localparam logic [2:0] MODE_GET_DOWN = 3'd5;
  localparam logic [2:0] MODE_FAULT    = 3'd6;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_DEADBAND    = 3'd1;
  localparam logic [2:0] REG_FULL_SCALE  = 3'd2;
  localparam logic [2:0] REG_ALPHA_FWD   = 3'd3;
  localparam logic [2:0] REG_ALPHA_TURN  = 3'd4;
  localparam logic [2:0] REG_SELECT_MASK = 3'd5;
  localparam logic [2:0] REG_START_MASK  = 3'd6;

  localparam logic [9:0]  DEADBAND_RST   = 10'd80;
  localparam logic [9:0]  FULL_SCALE_RST = 10'd660;
  localparam logic [15:0] ALPHA_RST      = 16'd13107;
  localparam logic [15:0] SELECT_RST     = 16'd1;
  localparam logic [15:0] START_RST      = 16'd8;
endpackage

// File: src/lmca_div.sv
// Restoring divider, one quotient bit per cycle, for the stick scale.
// Depends on lmca_pkg for widths.
`timescale 1ns / 1ps
module lmca_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       sat,
  input  logic [lmca_pkg::SCW-1:0]   num,
  input  logic [lmca_pkg::SCW-1:0]   den,
  output logic                       done,
  output logic [lmca_pkg::QW-1:0]    quo
);
  localparam logic [3:0] LAST = 4'(lmca_pkg::QW - 1);

  logic [lmca_pkg::SCW-1:0] rem_r, den_r;
  logic [lmca_pkg::QW-1:0]  quo_r;
  logic [3:0]               cnt_r;
  logic                     busy_r, sat_r, done_r;
  logic [lmca_pkg::SCW:0]   two, rem_sub;

  assign two     = {rem_r, 1'b0};
  assign rem_sub = two - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == LAST) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      sat_r <= sat;
      quo_r <= sat ? '1 : '0;
    end else if (busy_r && !sat_r) begin
      if (two >= {1'b0, den_r}) begin
        rem_r <= rem_sub[lmca_pkg::SCW-1:0];
        quo_r <= {quo_r[lmca_pkg::QW-2:0], 1'b1};
      end else begin
        rem_r <= two[lmca_pkg::SCW-1:0];
        quo_r <= {quo_r[lmca_pkg::QW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// File: src/lmca_lpf.sv
// Low-pass update by shift-add multiply, one alpha bit per cycle.
// Depends on lmca_pkg for widths.
`timescale 1ns / 1ps
module lmca_lpf (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [lmca_pkg::CW-1:0]   x,
  input  logic signed [lmca_pkg::CW-1:0]   prev,
  input  logic [lmca_pkg::CW-1:0]          alpha,
  output logic                             done,
  output logic signed [lmca_pkg::CW-1:0]   res
);
  localparam logic [3:0] LAST = 4'(lmca_pkg::CW - 1);

  logic signed [18:0]              hi_r, t;
  logic [lmca_pkg::CW-1:0]         lo_r, alpha_r;
  logic signed [16:0]              diff_r;
  logic signed [lmca_pkg::CW-1:0]  prev_r;
  logic [3:0]                      cnt_r;
  logic                            busy_r, done_r;

  assign t = hi_r + (alpha_r[0] ? {{2{diff_r[16]}}, diff_r} : 19'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == LAST) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r    <= '0;
      lo_r    <= '0;
      alpha_r <= alpha;
      prev_r  <= prev;
      diff_r  <= {x[lmca_pkg::CW-1], x} - {prev[lmca_pkg::CW-1], prev};
    end else if (busy_r) begin
      hi_r    <= {t[18], t[18:1]};
      lo_r    <= {t[0], lo_r[lmca_pkg::CW-1:1]};
      alpha_r <= {1'b0, alpha_r[lmca_pkg::CW-1:1]};
    end
  end

  assign res  = prev_r + hi_r[lmca_pkg::CW-1:0] + {15'd0, lo_r[lmca_pkg::CW-1]};
  assign done = done_r;
endmodule

// File: src/legged_motion_command_arbiter.sv
// Legged motion command arbiter: one request in, one result out.
// Input channel in_*, result channel out_* (valid/stall), write-only cfg_* port.
// A request that needs no filtering goes from ST_IDLE straight to ST_OUT; when the
// active stick axis is scaled and filtered it passes ST_DIV (serial divide) and
// ST_LPF (serial shift-add multiply) first. One request is in flight at a time;
// in_stall is high from acceptance until the result is placed in the output
// register, so a new request is taken only once the last result is registered.
// The result waits in the output register while out_stall is high; the block
// holds any finished result internally until that register frees, and takes
// no new request meanwhile.
// Synchronous active-low reset restores the default registers (disabled,
// deadband 80, full scale 660, alpha 13107, select mask 1, start mask 8),
// mode init and zero commands, and clears button synchronisation.
// Configuration writes are taken every cycle; write only while idle.
// Depends on lmca_pkg, lmca_div, lmca_lpf and legged_motion_command_arbiter_assert.svh.
`timescale 1ns / 1ps
`include "legged_motion_command_arbiter_assert.svh"
module legged_motion_command_arbiter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [2:0]         in_set_mode,
  input  logic               in_link_lost,
  input  logic [15:0]        in_buttons,
  input  logic signed [10:0] in_stick_forward,
  input  logic signed [10:0] in_stick_turn,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_mode,
  output logic signed [15:0] out_forward_cmd,
  output logic signed [15:0] out_turn_cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LPF  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic        enable_r;
  logic [9:0]  deadband_r, full_scale_r;
  logic [15:0] alpha_f_r, alpha_t_r, sel_mask_r, start_mask_r;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] prior_r, prior_nxt;
  logic        synced_r, synced_nxt, latch_r, latch_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic signed [15:0] sm_f_r, sm_f_nxt, sm_t_r, sm_t_nxt;
  logic signed [15:0] hold_f_r, hold_f_nxt, hold_t_r, hold_t_nxt;
  logic        axis_r, axis_nxt, neg_r, neg_nxt, go;

  logic        out_valid_r;
  logic [2:0]  out_mode_r;
  logic signed [15:0] out_fwd_r, out_turn_r;

  logic        accept;
  logic [10:0] mag_f, mag_t, mag_sel, num_w;
  logic [9:0]  den_w;
  logic        sat_w, fc, tc;
  logic [1:0]  fdir, tdir;
  logic        div_done, lpf_done;
  logic [14:0] quo;
  logic signed [15:0] vx, lpf_res;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      deadband_r   <= lmca_pkg::DEADBAND_RST;
      full_scale_r <= lmca_pkg::FULL_SCALE_RST;
      alpha_f_r    <= lmca_pkg::ALPHA_RST;
      alpha_t_r    <= lmca_pkg::ALPHA_RST;
      sel_mask_r   <= lmca_pkg::SELECT_RST;
      start_mask_r <= lmca_pkg::START_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lmca_pkg::REG_ENABLE:      enable_r     <= cfg_data[0];
        lmca_pkg::REG_DEADBAND:    deadband_r   <= cfg_data[9:0];
        lmca_pkg::REG_FULL_SCALE:  full_scale_r <= cfg_data[9:0];
        lmca_pkg::REG_ALPHA_FWD:   alpha_f_r    <= cfg_data;
        lmca_pkg::REG_ALPHA_TURN:  alpha_t_r    <= cfg_data;
        lmca_pkg::REG_SELECT_MASK: sel_mask_r   <= cfg_data;
        lmca_pkg::REG_START_MASK:  start_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mag_f = in_stick_forward[10] ? 11'(-in_stick_forward) : in_stick_forward;
  assign mag_t = in_stick_turn[10] ? 11'(-in_stick_turn) : in_stick_turn;
  assign fc    = mag_f <= {1'b0, deadband_r};
  assign tc    = mag_t <= {1'b0, deadband_r};
  assign fdir  = in_stick_forward[10] ? lmca_pkg::DIR_NEG : lmca_pkg::DIR_POS;
  assign tdir  = in_stick_turn[10] ? lmca_pkg::DIR_NEG : lmca_pkg::DIR_POS;

  assign mag_sel = axis_nxt ? mag_t : mag_f;
  assign num_w   = mag_sel - {1'b0, deadband_r};
  assign den_w   = full_scale_r - deadband_r;
  assign sat_w   = (full_scale_r <= deadband_r) || (num_w >= {1'b0, den_w});

  always_comb begin
    logic [15:0] rising;
    logic [2:0]  m;
    logic        proceed;
    rising     = '0;
    m          = mode_r;
    proceed    = 1'b0;
    mode_nxt   = mode_r;
    prior_nxt  = prior_r;
    synced_nxt = synced_r;
    dir_nxt    = dir_r;
    latch_nxt  = latch_r;
    sm_f_nxt   = sm_f_r;
    sm_t_nxt   = sm_t_r;
    hold_f_nxt = hold_f_r;
    hold_t_nxt = hold_t_r;
    axis_nxt   = axis_r;
    neg_nxt    = neg_r;
    go         = 1'b0;
    if (accept) begin
      priority if (in_cmd) begin
        mode_nxt = (in_set_mode > lmca_pkg::MODE_FAULT) ? lmca_pkg::MODE_FAULT : in_set_mode;
        {hold_f_nxt, hold_t_nxt, sm_f_nxt, sm_t_nxt} = '0;
        dir_nxt = lmca_pkg::DIR_NONE;
        latch_nxt = 1'b0;
      end else if (!enable_r) begin
        mode_nxt = mode_r;
      end else if (in_link_lost) begin
        {hold_f_nxt, hold_t_nxt, sm_f_nxt, sm_t_nxt} = '0;
        dir_nxt    = lmca_pkg::DIR_NONE;
        latch_nxt  = 1'b0;
        synced_nxt = 1'b0;
        prior_nxt  = '0;
        if (mode_r == lmca_pkg::MODE_WALK || mode_r == lmca_pkg::MODE_TURN)
          mode_nxt = lmca_pkg::MODE_STAND;
      end else begin
        if (synced_r) rising = in_buttons & ~prior_r;
        synced_nxt = 1'b1;
        prior_nxt  = in_buttons;
        priority if ((rising & sel_mask_r) != '0) begin
          if (mode_r != lmca_pkg::MODE_FAULT) begin
            mode_nxt = lmca_pkg::MODE_GET_DOWN;
            {hold_f_nxt, hold_t_nxt, sm_f_nxt, sm_t_nxt} = '0;
            dir_nxt = lmca_pkg::DIR_NONE;
            latch_nxt = 1'b0;
          end
        end else if ((rising & start_mask_r) != '0) begin
          if (mode_r == lmca_pkg::MODE_INIT || mode_r == lmca_pkg::MODE_GET_DOWN) begin
            mode_nxt = lmca_pkg::MODE_GET_UP;
            proceed  = 1'b1;
          end else if (mode_r == lmca_pkg::MODE_STAND || mode_r == lmca_pkg::MODE_WALK ||
                       mode_r == lmca_pkg::MODE_TURN) begin
            mode_nxt = lmca_pkg::MODE_STAND;
            proceed  = 1'b1;
          end
          if (proceed) begin
            {hold_f_nxt, hold_t_nxt, sm_f_nxt, sm_t_nxt} = '0;
            dir_nxt = lmca_pkg::DIR_NONE;
            latch_nxt = 1'b0;
          end
        end else begin
          hold_f_nxt = '0;
          hold_t_nxt = '0;
          if (mode_r == lmca_pkg::MODE_STAND || mode_r == lmca_pkg::MODE_WALK ||
              mode_r == lmca_pkg::MODE_TURN) begin
            if (fc && tc) begin
              mode_nxt  = lmca_pkg::MODE_STAND;
              dir_nxt   = lmca_pkg::DIR_NONE;
              latch_nxt = 1'b1;
              sm_f_nxt  = '0;
              sm_t_nxt  = '0;
            end else begin
              proceed = 1'b1;
              if (m == lmca_pkg::MODE_STAND) begin
                priority if (!latch_r) begin
                  proceed = 1'b0;
                end else if (!fc && tc) begin
                  m = lmca_pkg::MODE_WALK;
                  dir_nxt = fdir;
                  latch_nxt = 1'b0;
                end else if (fc && !tc) begin
                  m = lmca_pkg::MODE_TURN;
                  dir_nxt = tdir;
                  latch_nxt = 1'b0;
                end else begin
                  latch_nxt = 1'b0;
                  sm_f_nxt  = '0;
                  sm_t_nxt  = '0;
                  proceed   = 1'b0;
                end
              end
              mode_nxt = m;
              if (proceed) begin
                if ((m == lmca_pkg::MODE_WALK && (fc || !tc || fdir != dir_nxt)) ||
                    (m == lmca_pkg::MODE_TURN && (tc || !fc || tdir != dir_nxt))) begin
                  mode_nxt = lmca_pkg::MODE_STAND;
                  {hold_f_nxt, hold_t_nxt, sm_f_nxt, sm_t_nxt} = '0;
                  dir_nxt = lmca_pkg::DIR_NONE;
                  latch_nxt = 1'b0;
                end else begin
                  go       = 1'b1;
                  axis_nxt = (m == lmca_pkg::MODE_TURN);
                  neg_nxt  = (m == lmca_pkg::MODE_TURN) ? in_stick_turn[10]
                                                        : in_stick_forward[10];
                end
              end
            end
          end
        end
      end
    end
    if (lpf_done) begin
      if (axis_r) begin
        sm_t_nxt   = lpf_res;
        hold_t_nxt = lpf_res;
      end else begin
        sm_f_nxt   = lpf_res;
        hold_f_nxt = lpf_res;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = go ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_LPF;
      ST_LPF:  if (lpf_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= lmca_pkg::MODE_INIT;
      prior_r  <= '0;
      synced_r <= 1'b0;
      dir_r    <= lmca_pkg::DIR_NONE;
      latch_r  <= 1'b0;
      sm_f_r   <= '0;
      sm_t_r   <= '0;
      hold_f_r <= '0;
      hold_t_r <= '0;
      axis_r   <= 1'b0;
      neg_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      prior_r  <= prior_nxt;
      synced_r <= synced_nxt;
      dir_r    <= dir_nxt;
      latch_r  <= latch_nxt;
      sm_f_r   <= sm_f_nxt;
      sm_t_r   <= sm_t_nxt;
      hold_f_r <= hold_f_nxt;
      hold_t_r <= hold_t_nxt;
      axis_r   <= axis_nxt;
      neg_r    <= neg_nxt;
    end
  end

  lmca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go),
    .sat   (sat_w),
    .num   (num_w[9:0]),
    .den   (den_w),
    .done  (div_done),
    .quo   (quo)
  );

  assign vx = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  lmca_lpf u_lpf (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_done),
    .x     (vx),
    .prev  (axis_r ? sm_t_r : sm_f_r),
    .alpha (axis_r ? alpha_t_r : alpha_f_r),
    .done  (lpf_done),
    .res   (lpf_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_mode_r <= mode_r;
      out_fwd_r  <= hold_f_r;
      out_turn_r <= hold_t_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mode        = out_mode_r;
  assign out_forward_cmd = out_fwd_r;
  assign out_turn_cmd    = out_turn_r;

  `LMCA_ASSERT(a_div_in_div, !div_done || state_r == ST_DIV)
  `LMCA_ASSERT(a_lpf_in_lpf, !lpf_done || state_r == ST_LPF)
  `LMCA_ASSERT_NEXT(a_out_loads, state_r == ST_OUT && !out_valid_r, out_valid_r)
endmodule
